// ----- sv/acsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_pkg
// Shared widths, constants, register codes and payload types of the
// arctangent soft-clip waveshaper.
// ----------------------------------------------------------------------------
package acsd_pkg;

  localparam int SampleBits = 24;

  // configuration register widths
  localparam int DriveW   = 7;
  localparam int RangeW   = 19;
  localparam int BlendW   = 7;
  localparam int VolW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 19;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDrive  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRange  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgBlend  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgVolume = CfgIdxW'(3);

  // reset values
  localparam logic [DriveW-1:0] DriveRst  = DriveW'(100);
  localparam logic [RangeW-1:0] RangeRst  = RangeW'(100);
  localparam logic [BlendW-1:0] BlendRst  = BlendW'(100);
  localparam logic [VolW-1:0]   VolumeRst = VolW'(46395);

  localparam logic [BlendW-1:0] BlendFull = BlendW'(100);

  // pre-gain and cordic widths
  localparam int MagW      = SampleBits;
  localparam int Prod1W    = MagW + DriveW;
  localparam int YW        = Prod1W + RangeW;
  localparam int CordW     = YW + 3;
  localparam int CordSteps = 31;
  localparam int ZW        = 33;

  localparam logic [CordW-1:0] CordX0 = CordW'(64'd10000 << (SampleBits - 1));

  // round(atan(2^-i) * 2^30)
  function automatic logic [ZW-1:0] atan_tab(input int unsigned i);
    logic [ZW-1:0] v;
    case (i)
      0:       v = ZW'(843314857);
      1:       v = ZW'(497837829);
      2:       v = ZW'(263043837);
      3:       v = ZW'(133525159);
      4:       v = ZW'(67021687);
      5:       v = ZW'(33543516);
      6:       v = ZW'(16775851);
      7:       v = ZW'(8388437);
      8:       v = ZW'(4194283);
      9:       v = ZW'(2097149);
      default: v = ZW'(1) << (30 - i);
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic [RangeW-1:0] range;
    logic [BlendW-1:0] blend;
    logic [VolW-1:0]   vol;
  } cfg_t;

  typedef struct packed {
    logic [YW-1:0]                y;
    logic signed [SampleBits-1:0] sample;
  } cord_arg_t;

  typedef struct packed {
    logic                         nz;
    logic signed [ZW-1:0]         z;
    logic signed [SampleBits-1:0] sample;
  } cord_res_t;

endpackage

// ----- sv/acsd_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_cordic
// Vectoring cordic, one rotation per register stage, giving the angle of
// (x0, y) in Q30 radians together with the clean sample.
// ----------------------------------------------------------------------------
module acsd_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  acsd_pkg::cord_arg_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output acsd_pkg::cord_res_t  out_o
);
  import acsd_pkg::*;

  logic [CordSteps-1:0] vld_q;
  logic [CordSteps-1:0] vld_in;
  logic [CordSteps:0]   en;

  logic signed [CordW-1:0]      x_q   [CordSteps];
  logic signed [CordW-1:0]      y_q   [CordSteps];
  logic signed [ZW-1:0]         z_q   [CordSteps];
  logic                         nz_q  [CordSteps];
  logic signed [SampleBits-1:0] smp_q [CordSteps];

  // a stage may load when empty or when its item moves on
  always_comb begin
    en[CordSteps] = out_ready_i;
    for (int k = CordSteps - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign vld_in     = {vld_q[CordSteps-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < CordSteps; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  for (genvar k = 0; k < CordSteps; k++) begin : g_stage
    logic signed [CordW-1:0]      x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0]         z_in, z_d;
    logic                         nz_in;
    logic signed [SampleBits-1:0] smp_in;

    if (k == 0) begin : g_first
      assign x_in   = $signed(CordX0);
      assign y_in   = $signed(CordW'(in_i.y));
      assign z_in   = '0;
      assign nz_in  = |in_i.y;
      assign smp_in = in_i.sample;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
      assign nz_in  = nz_q[k-1];
      assign smp_in = smp_q[k-1];
    end

    always_comb begin
      if (!y_in[CordW-1]) begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + $signed(atan_tab(k));
      end else begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - $signed(atan_tab(k));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]   <= x_d;
        y_q[k]   <= y_d;
        z_q[k]   <= z_d;
        nz_q[k]  <= nz_in;
        smp_q[k] <= smp_in;
      end
    end
  end

  assign out_valid_o  = vld_q[CordSteps-1];
  assign out_o.nz     = nz_q[CordSteps-1];
  assign out_o.z      = z_q[CordSteps-1];
  assign out_o.sample = smp_q[CordSteps-1];

  // back pressure only ever starts from a waiting item at the end
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("cordic stalled with no item at its output");

  // x keeps its sign through every rotation unless a width is short
  a_x_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CordSteps-1] |-> !x_q[CordSteps-1][CordW-1])
    else $error("cordic x went negative");

endmodule

// ----- sv/acsd_post.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsd_post
// Scales the angle to (2/pi)*atan, mixes wet and clean samples, applies the
// output gain, divides by 100*65536 with rounding and saturates.
// ----------------------------------------------------------------------------
module acsd_post (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  acsd_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  acsd_pkg::cord_res_t          in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [acsd_pkg::SampleBits-1:0] out_o
);
  import acsd_pkg::*;

  localparam int NumStages = 9;
  localparam int ZuW       = 31;
  localparam int FpW       = ZuW + 32;
  localparam int Down      = 32 - SampleBits;
  localparam int WetW      = SampleBits + 1;
  localparam int MixW      = SampleBits + 8;
  localparam int PW        = MixW + VolW + 1;
  localparam int TW        = SampleBits + 7;
  localparam int RecipSh   = 38;
  localparam int RpW       = TW + 32;
  localparam int QW        = RpW - RecipSh;

  localparam logic [31:0]   TwoOverPi = 32'd2734261102;
  localparam logic [31:0]   Recip100  = 32'd2748779069;
  localparam logic [32:0]   FLimit    = 33'h0_8000_0000;
  localparam logic [PW-1:0] RoundHalf = PW'(3276800);
  localparam logic [7:0]    Hundred   = 8'd100;
  localparam logic signed [QW+1:0] SatMax = (QW+2)'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [QW+1:0] SatMin = -SatMax - 1;

  logic [NumStages-1:0] vld_q, vld_in;
  logic [NumStages:0]   en;

  always_comb begin
    en[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign vld_in     = {vld_q[NumStages-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // angle times 2/pi in q32, clamped at zero and skipped for a zero input
  logic [ZuW-1:0] zu;
  logic [FpW-1:0] fp_d, fp_q;
  logic signed [SampleBits-1:0] smp0_q;

  assign zu   = (in_i.nz && !in_i.z[ZW-1]) ? in_i.z[ZuW-1:0] : '0;
  assign fp_d = zu * TwoOverPi;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fp_q   <= fp_d;
      smp0_q <= in_i.sample;
    end
  end

  // q31 limit, round down to sample width, restore sign
  logic [32:0]            f_c, f_rnd;
  logic [SampleBits-1:0]  w;
  logic signed [WetW-1:0] wet_d, wet_q;
  logic signed [SampleBits-1:0] smp1_q;

  always_comb begin
    f_c = {1'b0, fp_q[FpW-1:31]};
    if (f_c > FLimit) begin
      f_c = FLimit;
    end
    f_rnd = f_c + 33'((1 << Down) >> 1);
    w     = f_rnd[Down +: SampleBits];
    wet_d = smp0_q[SampleBits-1] ? -$signed({1'b0, w}) : $signed({1'b0, w});
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      wet_q  <= wet_d;
      smp1_q <= smp0_q;
    end
  end

  // blend products
  logic [BlendW-1:0]      bc;
  logic [7:0]             inv;
  logic signed [WetW+8-1:0]       pw_full;
  logic signed [SampleBits+8-1:0] pc_full;
  logic signed [MixW-1:0] pw_q, pc_q;

  always_comb begin
    bc      = (cfg_i.blend > BlendFull) ? BlendFull : cfg_i.blend;
    inv     = Hundred - {1'b0, bc};
    pw_full = wet_q * $signed({2'b00, bc});
    pc_full = smp1_q * $signed({1'b0, inv});
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pw_q <= pw_full[MixW-1:0];
      pc_q <= pc_full[MixW-1:0];
    end
  end

  logic signed [MixW-1:0] m_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m_q <= pw_q + pc_q;
    end
  end

  logic signed [PW-1:0] p_d, p_q;

  assign p_d = m_q * $signed({1'b0, cfg_i.vol});

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p_q <= p_d;
    end
  end

  // rounding half away from zero: add half the divisor, drop the 65536 part
  logic [PW-1:0] mag, mag_rnd;
  logic [TW-1:0] t5_q;
  logic          neg5_q;

  always_comb begin
    mag     = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
    mag_rnd = mag + RoundHalf;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      t5_q   <= mag_rnd[16 +: TW];
      neg5_q <= p_q[PW-1];
    end
  end

  // divide by 100 through a floored reciprocal, off by at most one
  logic [RpW-1:0] rp_d, rp_q;
  logic [TW-1:0]  t6_q;
  logic           neg6_q;

  assign rp_d = t5_q * Recip100;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      rp_q   <= rp_d;
      t6_q   <= t5_q;
      neg6_q <= neg5_q;
    end
  end

  logic [QW-1:0] q0;
  logic [TW-1:0] q100, rem;
  logic [QW-1:0] q0_q;
  logic [7:0]    r_q;
  logic          neg7_q;

  always_comb begin
    q0   = rp_q[RecipSh +: QW];
    q100 = q0 * 7'd100;
    rem  = t6_q - q100;
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      q0_q   <= q0;
      r_q    <= rem[7:0];
      neg7_q <= neg6_q;
    end
  end

  logic [QW:0]            qc;
  logic signed [QW+1:0]   sq;
  logic signed [SampleBits-1:0] sat, out_q;

  always_comb begin
    qc = {1'b0, q0_q} + (QW+1)'(r_q >= Hundred);
    sq = neg7_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    if (sq > SatMax) begin
      sat = SatMax[SampleBits-1:0];
    end else if (sq < SatMin) begin
      sat = SatMin[SampleBits-1:0];
    end else begin
      sat = sq[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      out_q <= sat;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign out_o       = out_q;

  // the reciprocal estimate never falls more than one quotient short
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] |-> r_q < 8'd200)
    else $error("divide by 100 remainder out of range");

endmodule

// ----- sv/atan_soft_clip_distortion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_soft_clip_distortion
// Arctangent soft-clip waveshaper with wet/clean blend and output gain.
// ----------------------------------------------------------------------------
// One sample enters per clock unless back pressure stalls it, passing two
// pre-gain multiplier stages, the 31-stage cordic pipeline and nine stages of
// scaling, mixing, gain, division and saturation. Each stage holds its item
// until the next one has room, so empty slots close up under back pressure
// and input keeps being taken while a result waits at the output if a stage is empty.
// The user must write registers through the cfg port between bursts of
// samples; the block does not enforce this and keeps no state between samples.
module atan_soft_clip_distortion (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [acsd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [acsd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [acsd_pkg::SampleBits-1:0]   s_axis_tdata_i,   // [23:0] sample_in
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [acsd_pkg::SampleBits-1:0]   m_axis_tdata_o    // [23:0] sample_out
);
  import acsd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive <= DriveRst;
      cfg_q.range <= RangeRst;
      cfg_q.blend <= BlendRst;
      cfg_q.vol   <= VolumeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDrive:  cfg_q.drive <= cfg_wdata_i[DriveW-1:0];
        CfgRange:  cfg_q.range <= cfg_wdata_i[RangeW-1:0];
        CfgBlend:  cfg_q.blend <= cfg_wdata_i[BlendW-1:0];
        CfgVolume: cfg_q.vol   <= cfg_wdata_i[VolW-1:0];
        default: ;
      endcase
    end
  end

  // pre-gain: |sample| * drive, then * range
  logic [1:0] vld_q, vld_in;
  logic [2:0] en;
  logic       cord_ready;

  assign en[2] = cord_ready;
  assign en[1] = ~vld_q[1] | en[2];
  assign en[0] = ~vld_q[0] | en[1];

  assign vld_in          = {vld_q[0], s_axis_tvalid_i};
  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= vld_in[0];
      end
      if (en[1]) begin
        vld_q[1] <= vld_in[1];
      end
    end
  end

  logic signed [SampleBits-1:0] smp_in, smp1_q, smp2_q;
  logic [MagW-1:0]   mag;
  logic [Prod1W-1:0] p1_d, p1_q;
  logic [YW-1:0]     y_d, y_q;

  assign smp_in = $signed(s_axis_tdata_i);
  assign mag    = smp_in[SampleBits-1] ? MagW'(-smp_in) : MagW'(smp_in);
  assign p1_d   = mag * cfg_q.drive;
  assign y_d    = p1_q * cfg_q.range;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q   <= p1_d;
      smp1_q <= smp_in;
    end
    if (en[1]) begin
      y_q    <= y_d;
      smp2_q <= smp1_q;
    end
  end

  cord_arg_t cord_arg;
  cord_res_t cord_res;
  logic      cord_valid, post_ready;

  assign cord_arg.y      = y_q;
  assign cord_arg.sample = smp2_q;

  acsd_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[1]),
    .in_ready_o  (cord_ready),
    .in_i        (cord_arg),
    .out_valid_o (cord_valid),
    .out_ready_i (post_ready),
    .out_o       (cord_res)
  );

  logic signed [SampleBits-1:0] out_sample;

  acsd_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (cord_valid),
    .in_ready_o  (post_ready),
    .in_i        (cord_res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_sample)
  );

  assign m_axis_tdata_o = out_sample;

  // input is refused only when a finished item sits unclaimed at the output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input refused without output back pressure");

endmodule

// ----- tb/atan_clip_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_clip_checker
// Watches the register port and both sample streams of the arctangent
// soft-clip waveshaper, works out every output sample from its own copy of
// the registers and compares it with what the block delivers, in order.
// ----------------------------------------------------------------------------
module atan_clip_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acsd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [acsd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [acsd_pkg::SampleBits-1:0] in_data_i,   // [23:0] sample_in
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [acsd_pkg::SampleBits-1:0] out_data_i,  // [23:0] sample_out
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);
  import acsd_pkg::*;

  localparam longint unsigned TwoOverPiQ32 = 64'd2734261102;
  localparam longint unsigned MixDiv       = 64'd6553600;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_in;
    logic signed [SampleBits-1:0] sample_out;
  } clip_pair_t;

  clip_pair_t expected_clip_q[$];

  logic [DriveW-1:0] drive_q;
  logic [RangeW-1:0] range_q;
  logic [BlendW-1:0] blend_q;
  logic [VolW-1:0]   vol_q;

  longint atan_q30 [CordSteps];
  int     err_cnt;
  int     chk_cnt;

  assign errors_o  = err_cnt;
  assign checked_o = chk_cnt;

  initial begin
    atan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                 128, 64, 32, 16, 8, 4, 2, 1};
  end

  // drive*range pre-gain, (2/pi)*atan via vectoring cordic, blend, gain, saturate
  function automatic logic signed [SampleBits-1:0] clip_sample(
    input logic signed [SampleBits-1:0] smp
  );
    longint s, a, num, x, y, z, xo, wet, m, p, q, b, maxv;
    longint unsigned f, w, mag;
    int i;
    s    = smp;
    a    = (s < 0) ? -s : s;
    num  = a * longint'(drive_q) * longint'(range_q);
    maxv = (longint'(1) << (SampleBits - 1)) - 1;
    f    = 0;
    if (num != 0) begin
      x = longint'(10000) << (SampleBits - 1);
      y = num;
      z = 0;
      for (i = 0; i < CordSteps; i++) begin
        xo = x;
        if (y >= 0) begin
          x += y >>> i;
          y -= xo >>> i;
          z += atan_q30[i];
        end else begin
          x -= y >>> i;
          y += xo >>> i;
          z -= atan_q30[i];
        end
      end
      if (z < 0) z = 0;
      f = ($unsigned(z) * TwoOverPiQ32) >> 31;
      if (f > (64'd1 << 31)) f = 64'd1 << 31;
    end
    // round half up down to sample width
    w   = (f + (64'd1 << (31 - SampleBits))) >> (32 - SampleBits);
    wet = (s < 0) ? -longint'(w) : longint'(w);
    b   = (blend_q > BlendFull) ? 100 : longint'(blend_q);
    m   = wet * b + s * (100 - b);
    p   = m * longint'(vol_q);
    mag = (p < 0) ? -p : p;
    mag = (mag + MixDiv / 2) / MixDiv;
    q   = (p < 0) ? -longint'(mag) : longint'(mag);
    if (q > maxv) q = maxv;
    if (q < -maxv - 1) q = -maxv - 1;
    return q[SampleBits-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    clip_pair_t exp_item;
    if (!rst_ni) begin
      drive_q = DriveRst;
      range_q = RangeRst;
      blend_q = BlendRst;
      vol_q   = VolumeRst;
      expected_clip_q.delete();
      err_cnt   = 0;
      chk_cnt   = 0;
      pending_o = 0;
    end else begin
      // results leave first so a same-edge input never shifts the order
      if (out_valid_i && out_ready_i) begin
        if (expected_clip_q.size() == 0) begin
          $error("sample_out %0d arrived with no sample pending", $signed(out_data_i));
          err_cnt++;
        end else begin
          exp_item = expected_clip_q.pop_front();
          chk_cnt++;
          if (out_data_i !== exp_item.sample_out) begin
            $error("sample_out mismatch (sample_in %0d): expected %0d, actual %0d",
                   exp_item.sample_in, exp_item.sample_out, $signed(out_data_i));
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_item.sample_in  = in_data_i;
        exp_item.sample_out = clip_sample(in_data_i);
        expected_clip_q.push_back(exp_item);
      end
      // register writes take effect after this edge's item
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDrive:  drive_q = cfg_wdata_i[DriveW-1:0];
          CfgRange:  range_q = cfg_wdata_i[RangeW-1:0];
          CfgBlend:  blend_q = cfg_wdata_i[BlendW-1:0];
          CfgVolume: vol_q   = cfg_wdata_i[VolW-1:0];
          default:   ;
        endcase
      end
      pending_o = expected_clip_q.size();
    end
  end

endmodule

// ----- tb/tb_atan_soft_clip_distortion.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atan_soft_clip_distortion
// Streams audio samples through the soft-clip waveshaper under a series of
// register settings (reset values, extremes, spare indexes, random), with
// random idle cycles on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_atan_soft_clip_distortion;
  import acsd_pkg::*;

  localparam int Latency    = 42;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 50;
  localparam int NumPhases  = 8;

  localparam logic [CfgIdxW-1:0] CfgFirstSpare = CfgVolume + 1'b1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_idx;
  logic [CfgDataW-1:0]   cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SampleBits-1:0] s_tdata;    // [23:0] sample_in
  logic                  m_tvalid;
  logic                  m_tready;
  logic [SampleBits-1:0] m_tdata;    // [23:0] sample_out

  int errors;
  int pending;
  int checked;

  int src_gap_max;
  int sink_gap_max;
  bit sink_hold_req;
  int n_sent;
  int n_settings;

  atan_soft_clip_distortion DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  atan_clip_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("tb_atan_soft_clip_distortion: errors");
    $finish;
  end

  // output side: random stalls per item, or one long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, sink_gap_max);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_sample(input logic [SampleBits-1:0] smp);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // junk above the register width must be dropped by the block
  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned val, input int width);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom) << width;
    return junk | CfgDataW'(val);
  endfunction

  function automatic logic [SampleBits-1:0] draw_sample();
    logic [SampleBits-1:0] v;
    int k;
    case ($urandom_range(0, 3))
      0, 1: v = SampleBits'($urandom);
      2: begin
        k = $urandom_range(0, SampleBits - 2);
        v = SampleBits'($urandom_range(0, 1 << k));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = SampleBits'($urandom_range(0, 15));
        v = $urandom_range(0, 1) ? ({1'b1, {(SampleBits-1){1'b0}}} + v)
                                 : ({1'b0, {(SampleBits-1){1'b1}}} - v);
      end
    endcase
    return v;
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // drive, range, blend, volume for each phase; phase zero keeps reset values
  task automatic apply_phase(input int ph);
    int unsigned drv, rng, bln, vol;
    int k;
    drv = $urandom_range(0, (1 << DriveW) - 1);
    rng = $urandom_range(0, (1 << RangeW) - 1);
    bln = $urandom_range(0, (1 << BlendW) - 1);
    vol = $urandom_range(0, (1 << VolW) - 1);
    case (ph)
      1: begin drv = 1;   rng = 300000; bln = 100; vol = 65535; end
      2: begin drv = 0;   rng = 524287; bln = 50;  vol = 46395; end
      3: begin drv = 100; rng = 0;      bln = 0;   vol = 16;    end
      4: begin drv = 127; rng = 524287; bln = 127; vol = 65535; end
      6: begin drv = 50;  rng = 1000;   bln = 75;  vol = 32768; end
      default: ;
    endcase
    write_reg(CfgDrive, with_junk(drv, DriveW));
    write_reg(CfgRange, with_junk(rng, RangeW));
    write_reg(CfgBlend, with_junk(bln, BlendW));
    write_reg(CfgVolume, with_junk(vol, VolW));
    // spare indexes must leave every register alone
    if (ph == 6) begin
      for (k = CfgFirstSpare; k < (1 << CfgIdxW); k++) write_reg(CfgIdxW'(k), CfgDataW'($urandom));
    end
    n_settings++;
  endtask

  initial begin
    logic [SampleBits-1:0] directed [14];
    int ph, n, wait_cnt;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgDrive;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    src_gap_max   = 0;
    sink_gap_max  = 0;
    sink_hold_req = 1'b0;
    n_sent        = 0;
    n_settings    = 1;
    directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                 24'h800001, 24'h7FFFFE, 24'h400000, 24'hC00000, 24'h000002,
                 24'hFFFFFE, 24'h0003E8, 24'hFFFC18, 24'h555555};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings, back to back first
    foreach (directed[i]) push_sample(directed[i]);
    src_gap_max  = 18;
    sink_gap_max = 18;
    for (n = 0; n < PhaseItems - 10; n++) push_sample(draw_sample());

    for (ph = 1; ph < NumPhases; ph++) begin
      drain(Latency + 8);
      apply_phase(ph);
      if (ph == 1) begin
        src_gap_max  = 18;
        sink_gap_max = 18;
      end else begin
        src_gap_max  = pick_gap_max();
        sink_gap_max = pick_gap_max();
      end
      if (ph == 5) begin
        // output held off while input runs flat out: pipeline fills and stalls
        src_gap_max   = 0;
        sink_hold_req = 1'b1;
        for (n = 0; n < 2 * PhaseItems; n++) push_sample(draw_sample());
      end else begin
        for (n = 0; n < PhaseItems; n++) begin
          if (ph == 7 && n == PhaseItems / 2) drain(0);
          push_sample(draw_sample());
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (Latency + 20) @(negedge clk_i);
    if (pending != 0) $error("%0d output samples never arrived", pending);

    $display("run: %0d samples under %0d register settings, %0d outputs compared",
             n_sent, n_settings, checked);
    $display("run: extremes, spare indexes, one %0d-cycle output hold-off", HoldCycles);
    if (errors == 0 && pending == 0) begin
      $display("tb_atan_soft_clip_distortion: clean");
    end else begin
      $display("tb_atan_soft_clip_distortion: errors");
    end
    $finish;
  end

endmodule
